// ===== rtl/pfms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfms_pkg
// shared types, character codes and size constants of the format size parser
// ----------------------------------------------------------------------------
package pfms_pkg;

  localparam int SUM_W     = 8;
  localparam int DIV_STEPS = SUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int UID_W     = 4;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [SUM_W-1:0] PDL_MAX     = SUM_W'(231);
  localparam logic [SUM_W:0]   ASCII_BYTES = (SUM_W+1)'(32);

  // register index, taken from paddr[2]
  localparam logic REG_UID_SIZE = 1'b0;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_B_UP  = 8'h42;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_W_UP  = 8'h57;
  localparam logic [7:0] CH_W_LO  = 8'h77;
  localparam logic [7:0] CH_D_UP  = 8'h44;
  localparam logic [7:0] CH_D_LO  = 8'h64;
  localparam logic [7:0] CH_U_UP  = 8'h55;
  localparam logic [7:0] CH_U_LO  = 8'h75;
  localparam logic [7:0] CH_V_UP  = 8'h56;
  localparam logic [7:0] CH_V_LO  = 8'h76;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_HEX1,
    PH_HEX2,
    PH_AFTER,
    PH_WAIT
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pd_format_max_size_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pd_format_max_size_parser_top
// streams a parameter format string and reports its maximum data length
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one format character per word; a zero word ends the string
//   and produces exactly one out_max_size word. other words produce nothing.
//   characters are taken one per cycle while the result register is free
//   and the remainder unit is idle. a zero word's result is registered in the
//   cycle after acceptance, except for an unterminated string with a nonzero
//   sum outside a hex escape: the remainder unit then runs 231 mod sum one bit
//   per cycle, the input is stalled meanwhile, and 231 minus it is registered.
//   a stalled result is held in the output register; while it waits, the
//   input is stalled as well.
//   uid_size is written over the apb port at address 0 (reset value 6); the
//   user must write it only while the block is idle, which is not enforced.
//   reset (rst_n low, synchronous) clears the parse state, the output valid
//   and the remainder unit.
// ----------------------------------------------------------------------------
module pd_format_max_size_parser_top import pfms_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_ch,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_max_size,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  phase_t           phase_r, phase_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] dec_r, dec_nxt;
  logic [UID_W-1:0] uid_r;
  logic             oval_r, oval_nxt;
  logic [7:0]       out_r, out_nxt;
  logic             in_acc;
  logic             div_start;
  logic             res_ld;
  logic [7:0]       res_val;
  logic [SUM_W:0]   add_amt;
  logic [SUM_W:0]   sum_add;
  logic             ovf;
  logic             tok_add;
  logic             tok_end;
  div_stat_t        dstat;
  logic [SUM_W-1:0] drem;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_UID_SIZE) ?
                      {{(DATA_W-UID_W){1'b0}}, uid_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uid_r <= UID_W'(6);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_UID_SIZE) begin
      uid_r <= cfg_pwdata[UID_W-1:0];
    end
  end

  // handshake
  assign in_stall = dstat.busy | dstat.done | (oval_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  // token decode
  always_comb begin
    tok_add = 1'b0;
    tok_end = 1'b0;
    add_amt = (SUM_W+1)'(1);
    case (in_ch) inside
      CH_B_UP, CH_B_LO: begin
        tok_add = 1'b1;
      end
      CH_W_UP, CH_W_LO: begin
        tok_add = 1'b1;
        add_amt = (SUM_W+1)'(2);
      end
      CH_D_UP, CH_D_LO: begin
        tok_add = 1'b1;
        add_amt = (SUM_W+1)'(4);
      end
      CH_U_UP, CH_U_LO: begin
        tok_add = 1'b1;
        add_amt = {{(SUM_W+1-UID_W){1'b0}}, uid_r};
      end
      CH_V_UP, CH_V_LO: begin
        tok_add = 1'b1;
        tok_end = 1'b1;
        add_amt = {{(SUM_W+1-UID_W){1'b0}}, uid_r};
      end
      CH_A_UP, CH_A_LO: begin
        tok_add = 1'b1;
        tok_end = 1'b1;
        add_amt = ASCII_BYTES;
      end
      CH_DOLLAR: begin
        tok_add = 1'b1;
        tok_end = 1'b1;
        add_amt = '0;
      end
      default: begin
      end
    endcase
    // second hex digit always counts one byte
    if (phase_r == PH_HEX2) begin
      add_amt = (SUM_W+1)'(1);
    end
    sum_add = {1'b0, sum_r} + add_amt;
    ovf     = sum_add > {1'b0, PDL_MAX};
  end

  // parse state machine
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    dec_nxt   = dec_r;
    div_start = 1'b0;
    res_ld    = 1'b0;
    res_val   = '0;
    if (in_acc) begin
      if (in_ch == CH_NUL) begin
        phase_nxt = PH_SCAN;
        sum_nxt   = '0;
        dec_nxt   = '0;
        if (phase_r == PH_SCAN && sum_r != '0) begin
          div_start = 1'b1;
        end else begin
          res_ld = 1'b1;
          unique case (phase_r)
            PH_AFTER: res_val = sum_r;
            PH_WAIT:  res_val = dec_r;
            default:  res_val = '0;
          endcase
        end
      end else begin
        unique case (phase_r)
          PH_SCAN: begin
            if (in_ch == CH_SPACE) begin
              phase_nxt = PH_SCAN;
            end else if (in_ch == CH_X_UP || in_ch == CH_X_LO) begin
              phase_nxt = PH_HEX1;
            end else if (tok_add && !ovf) begin
              sum_nxt = sum_add[SUM_W-1:0];
              if (tok_end) begin
                phase_nxt = PH_AFTER;
              end
            end else begin
              dec_nxt   = '0;
              phase_nxt = PH_WAIT;
            end
          end
          PH_HEX1: begin
            if (is_hex(in_ch)) begin
              phase_nxt = PH_HEX2;
            end else begin
              dec_nxt   = '0;
              phase_nxt = PH_WAIT;
            end
          end
          PH_HEX2: begin
            if (is_hex(in_ch) && !ovf) begin
              sum_nxt   = sum_add[SUM_W-1:0];
              phase_nxt = PH_SCAN;
            end else begin
              dec_nxt   = '0;
              phase_nxt = PH_WAIT;
            end
          end
          PH_AFTER: begin
            dec_nxt   = (in_ch == CH_DOLLAR) ? sum_r : '0;
            phase_nxt = PH_WAIT;
          end
          PH_WAIT: begin
            phase_nxt = PH_WAIT;
          end
          default: begin
            phase_nxt = PH_WAIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCAN;
      sum_r   <= '0;
      dec_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      dec_r   <= dec_nxt;
    end
  end

  pfms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PDL_MAX),
    .divisor  (sum_r),
    .stat     (dstat),
    .rem      (drem)
  );

  // output register
  always_comb begin
    oval_nxt = oval_r;
    out_nxt  = out_r;
    if (oval_r && !out_stall) begin
      oval_nxt = 1'b0;
    end
    if (dstat.done) begin
      oval_nxt = 1'b1;
      out_nxt  = PDL_MAX - drem;
    end else if (res_ld) begin
      oval_nxt = 1'b1;
      out_nxt  = res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid    = oval_r;
  assign out_max_size = out_r;

`ifndef SYNTHESIS
  // remainder result never lands on a pending word
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.done |-> !oval_r)
    else $error("remainder done while output word pending");

  // no new character while the remainder unit runs
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (dstat.busy || dstat.done) |-> in_stall)
    else $error("input accepted during remainder run");

  // string ending inside a hex escape reports zero
  a_hex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch == CH_NUL && (phase_r == PH_HEX1 || phase_r == PH_HEX2))
    |=> (oval_r && out_r == '0))
    else $error("unfinished hex escape gave nonzero size");

  // sizes stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r |-> (out_r <= PDL_MAX))
    else $error("max size out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/pfms_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfms_div
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfms_div import pfms_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [SUM_W-1:0] divisor,
  output div_stat_t             stat,
  output logic      [SUM_W-1:0] rem
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] dvd_r, dvd_nxt;
  logic [SUM_W-1:0] dvs_r, dvs_nxt;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;

  always_comb begin
    trial    = {rem_r, dvd_r[SUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule
`default_nettype wire

// ===== sim/tb_pd_format_max_size_parser_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pd_format_max_size_parser_top
// streams format strings one character word at a time into the size parser,
// predicts each string's maximum data length and compares the result words
// in order, over several uid_size settings with random gaps on both sides
// ----------------------------------------------------------------------------
module tb_pd_format_max_size_parser_top import pfms_pkg::*; ();

  localparam int PHASE_CHARS   = 210;
  localparam int SETTLE_CYCLES = 14;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 250;

  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_F_UP = 8'h46;
  localparam logic [7:0] CH_F_LO = 8'h66;
  localparam logic [7:0] CH_Q_LO = 8'h71;

  localparam logic [ADDR_W-1:0] UID_ADDR = ADDR_W'(4 * int'(REG_UID_SIZE));

  localparam logic [UID_W-1:0] UID_PLAN [5] = '{4'd15, 4'd0, 4'd8, 4'd7, 4'd6};

  localparam logic [7:0] DIRECTED_STR [25] = '{
    CH_NUL,
    CH_SPACE, CH_NUL,
    CH_X_UP, CH_9, CH_NUL,
    CH_X_LO, CH_NUL,
    CH_A_LO, CH_DOLLAR, 8'hFF, CH_NUL,
    CH_V_UP, CH_SPACE, CH_NUL,
    CH_Q_LO, CH_NUL,
    CH_W_LO, CH_X_LO, CH_F_UP, CH_0, CH_B_UP, CH_NUL,
    CH_DOLLAR, CH_NUL
  };

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [7:0]        in_ch       = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [7:0]        out_max_size;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  logic [7:0] char_q [$];
  logic [7:0] size_q [$];
  int         push_cnt  = 0;
  int         acc_cnt   = 0;
  int         err_cnt   = 0;

  logic       in_taken  = 1'b0;
  int         in_gap    = 0;
  int         calm_left = 0;
  int         in_roll;
  int         stall_left = 0;
  int         hold_left  = 0;
  logic       hold_done  = 1'b0;
  int         st_roll;
  int         idle_cycles = 0;

  // predictor state
  logic [UID_W-1:0] uid_cfg = 4'd6;
  phase_t           ph      = PH_SCAN;
  logic [7:0]       sum     = '0;
  logic             term    = 1'b0;
  logic [7:0]       held    = '0;
  logic             pred_emit;
  logic [7:0]       pred_sz;

  pd_format_max_size_parser_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_max_size (out_max_size),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_A_UP && c <= CH_F_UP) ||
           (c >= CH_A_LO && c <= CH_F_LO);
  endfunction

  task automatic add_len(input int n, input logic ends);
    int s;
    s = int'(sum) + n;
    if (s > int'(PDL_MAX)) begin
      held = '0;
      ph = PH_WAIT;
    end else begin
      sum = 8'(s);
      if (ends) begin
        term = 1'b1;
        ph = PH_AFTER;
      end
    end
  endtask

  task automatic fmt_step(input logic [7:0] c, output logic emit, output logic [7:0] sz);
    emit = 1'b0;
    sz = '0;
    if (c == CH_NUL) begin
      emit = 1'b1;
      case (ph)
        PH_SCAN: begin
          if (!term && sum != 0) sz = 8'(int'(PDL_MAX) - (int'(PDL_MAX) % int'(sum)));
          else if (term) sz = sum;
        end
        PH_AFTER: sz = sum;
        PH_WAIT: sz = held;
        default: sz = '0;
      endcase
      ph = PH_SCAN;
      sum = '0;
      term = 1'b0;
      held = '0;
    end else begin
      case (ph)
        PH_SCAN: begin
          case (c)
            CH_SPACE: ;
            CH_B_LO, CH_B_UP: add_len(1, 1'b0);
            CH_W_LO, CH_W_UP: add_len(2, 1'b0);
            CH_D_LO, CH_D_UP: add_len(4, 1'b0);
            CH_U_LO, CH_U_UP: add_len(int'(uid_cfg), 1'b0);
            CH_V_LO, CH_V_UP: add_len(int'(uid_cfg), 1'b1);
            CH_A_LO, CH_A_UP: add_len(int'(ASCII_BYTES), 1'b1);
            CH_DOLLAR: add_len(0, 1'b1);
            CH_X_LO, CH_X_UP: ph = PH_HEX1;
            default: begin
              held = '0;
              ph = PH_WAIT;
            end
          endcase
        end
        PH_HEX1: begin
          if (hex_digit(c)) begin
            ph = PH_HEX2;
          end else begin
            held = '0;
            ph = PH_WAIT;
          end
        end
        PH_HEX2: begin
          if (hex_digit(c)) begin
            ph = PH_SCAN;
            add_len(1, 1'b0);
          end else begin
            held = '0;
            ph = PH_WAIT;
          end
        end
        PH_AFTER: begin
          held = (c == CH_DOLLAR) ? sum : 8'd0;
          ph = PH_WAIT;
        end
        default: ph = PH_WAIT;
      endcase
    end
  endtask

  function automatic logic [7:0] either(input logic [7:0] lo, input logic [7:0] up);
    return $urandom_range(0, 1) ? up : lo;
  endfunction

  function automatic logic [7:0] rand_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_0 + 8'(r);
    if (r < 16) return CH_A_LO + 8'(r - 10);
    return CH_A_UP + 8'(r - 16);
  endfunction

  // words marked corrupt get a random nonzero character instead, one time in twelve
  task automatic put_char(input logic [7:0] c, input logic corrupt);
    if (corrupt && $urandom_range(0, 11) == 0) c = 8'($urandom_range(1, 255));
    char_q.push_back(c);
    push_cnt++;
  endtask

  task automatic drain();
    while (acc_cnt != push_cnt || size_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (char_q.size() > 0) begin
        in_valid <= 1'b1;
        in_ch <= char_q.pop_front();
        if (calm_left > 0) begin
          calm_left = calm_left - 1;
          in_gap = 0;
        end else begin
          in_roll = $urandom_range(0, 99);
          if (in_roll < 3) calm_left = $urandom_range(20, 60);
          if (in_roll < 55) in_gap = 0;
          else if (in_roll < 93) in_gap = $urandom_range(1, 3);
          else in_gap = $urandom_range(8, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, with one long hold-off to back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && acc_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else begin
      st_roll = $urandom_range(0, 99);
      if (st_roll < 40) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 30);
      end else if (st_roll < 92) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (size_q.size() == 0) begin
          report_mismatch($sformatf("max_size %0d with nothing expected", out_max_size));
        end else if (out_max_size !== size_q[0]) begin
          report_mismatch($sformatf("max_size got %0d expected %0d", out_max_size, size_q[0]));
          void'(size_q.pop_front());
        end else begin
          void'(size_q.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        acc_cnt++;
        fmt_step(in_ch, pred_emit, pred_sz);
        if (pred_emit) size_q.push_back(pred_sz);
      end
      in_taken <= in_valid && !in_stall;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stim
    int stop_at;
    int roll;
    int n;
    int k;
    logic bad;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED_STR[i]) put_char(DIRECTED_STR[i], 1'b0);

    foreach (UID_PLAN[p]) begin
      drain();
      @(negedge clk);
      cfg_psel = 1'b1;
      cfg_pwrite = 1'b1;
      cfg_paddr = UID_ADDR;
      cfg_pwdata = DATA_W'(UID_PLAN[p]);
      @(negedge clk);
      cfg_penable = 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      uid_cfg = UID_PLAN[p];
      @(negedge clk);
      cfg_pwrite = 1'b0;
      cfg_penable = 1'b0;
      @(negedge clk);
      cfg_penable = 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      if (cfg_prdata[UID_W-1:0] !== UID_PLAN[p])
        report_mismatch($sformatf("uid_size read %0d expected %0d",
                                  cfg_prdata[UID_W-1:0], UID_PLAN[p]));
      @(negedge clk);
      cfg_psel = 1'b0;
      cfg_penable = 1'b0;

      stop_at = push_cnt + PHASE_CHARS;
      while (push_cnt < stop_at) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          // noise
          n = $urandom_range(0, 6);
          repeat (n) put_char(8'($urandom_range(1, 255)), 1'b0);
        end else if (roll < 10) begin
          // long strings around the size limit
          n = $urandom_range(52, 58);
          repeat (n) put_char(either(CH_D_LO, CH_D_UP), 1'b0);
          k = $urandom_range(0, 4);
          case (k)
            0: put_char(either(CH_B_LO, CH_B_UP), 1'b0);
            1: put_char(either(CH_W_LO, CH_W_UP), 1'b0);
            2: put_char(either(CH_A_LO, CH_A_UP), 1'b0);
            3: put_char(either(CH_U_LO, CH_U_UP), 1'b0);
            default: ;
          endcase
        end else begin
          bad = (roll < 25);
          n = $urandom_range(0, 6);
          repeat (n) begin
            k = $urandom_range(0, 9);
            case (k)
              0: put_char(either(CH_B_LO, CH_B_UP), bad);
              1: put_char(either(CH_W_LO, CH_W_UP), bad);
              2, 8: put_char(either(CH_D_LO, CH_D_UP), bad);
              3, 4: put_char(either(CH_U_LO, CH_U_UP), bad);
              5, 6: begin
                put_char(either(CH_X_LO, CH_X_UP), bad);
                put_char(rand_hex(), bad);
                put_char(rand_hex(), bad);
              end
              default: put_char(CH_SPACE, bad);
            endcase
          end
          k = $urandom_range(0, 6);
          case (k)
            2, 3, 4: begin
              if (k == 2) put_char(either(CH_V_LO, CH_V_UP), bad);
              else if (k == 3) put_char(either(CH_A_LO, CH_A_UP), bad);
              else put_char(CH_DOLLAR, bad);
              if ($urandom_range(0, 3) == 0) begin
                put_char(CH_DOLLAR, bad);
                repeat ($urandom_range(0, 3)) put_char(8'($urandom_range(1, 255)), 1'b0);
              end
            end
            5: begin
              // truncated hex escape
              put_char(either(CH_X_LO, CH_X_UP), bad);
              if ($urandom_range(0, 1)) put_char(rand_hex(), bad);
            end
            default: ;
          endcase
        end
        put_char(CH_NUL, 1'b0);
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
